[hw/rtl/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_pkg
// shared constants, mode codes and the arctangent table of the converter
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF = 16;
  localparam int MAX_ITER       = 32;
  localparam int GUARD          = 16;
  localparam int ANGLE_W        = 34;
  localparam int SPLIT_W        = 24;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sh080000000;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sh040000000;

  localparam logic FUNC_TO_POLAR = 1'b0;
  localparam logic FUNC_TO_RECT  = 1'b1;

  // arctangent of 2^-idx in units of pi/2^31, truncated
  function automatic logic [31:0] rpc_atan(input int idx);
    logic [31:0] val;
    case (idx)
      0:  val = 32'h20000000;
      1:  val = 32'h12E4051E;
      2:  val = 32'h09FB385B;
      3:  val = 32'h051111D4;
      4:  val = 32'h028B0D43;
      5:  val = 32'h0145D7E1;
      6:  val = 32'h00A2F61E;
      7:  val = 32'h00517C55;
      8:  val = 32'h0028BE53;
      9:  val = 32'h00145F2F;
      10: val = 32'h000A2F98;
      11: val = 32'h000517CC;
      12: val = 32'h00028BE6;
      13: val = 32'h000145F3;
      14: val = 32'h0000A2F9;
      15: val = 32'h0000517C;
      16: val = 32'h000028BE;
      17: val = 32'h0000145F;
      18: val = 32'h00000A2F;
      19: val = 32'h00000517;
      20: val = 32'h0000028B;
      21: val = 32'h00000145;
      22: val = 32'h000000A2;
      23: val = 32'h00000051;
      24: val = 32'h00000028;
      25: val = 32'h00000014;
      26: val = 32'h0000000A;
      27: val = 32'h00000005;
      28: val = 32'h00000002;
      29: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/rpc_pre.sv]
// ----------------------------------------------------------------------------
// rpc_pre
// input register stage: scales the operands and folds them into the
// right half plane before the iterations
// ----------------------------------------------------------------------------
module rpc_pre
  import rpc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int XW = DATA_WIDTH + GUARD + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_func,
  output logic signed [XW-1:0]         out_x,
  output logic signed [XW-1:0]         out_y,
  output logic signed [ANGLE_W-1:0]    out_z
);

  localparam int ASH = 32 - DATA_WIDTH;

  logic signed [XW-1:0]      xa;
  logic signed [XW-1:0]      yb;
  logic signed [ANGLE_W-1:0] zb;
  logic signed [XW-1:0]      x_next;
  logic signed [XW-1:0]      y_next;
  logic signed [ANGLE_W-1:0] z_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    xa = $signed({{3{operand_a[DATA_WIDTH-1]}}, operand_a, {GUARD{1'b0}}});
    yb = $signed({{3{operand_b[DATA_WIDTH-1]}}, operand_b, {GUARD{1'b0}}});
    zb = $signed({{(ANGLE_W-DATA_WIDTH){operand_b[DATA_WIDTH-1]}}, operand_b}) <<< ASH;
    x_next = xa;
    y_next = '0;
    z_next = '0;
    if (func == FUNC_TO_POLAR) begin
      y_next = yb;
      // left half plane: turn by pi
      if (xa < 0) begin
        x_next = -xa;
        y_next = -yb;
        z_next = (yb >= 0) ? HALF_TURN : -HALF_TURN;
      end
    end else begin
      z_next = zb;
      if (zb > QUARTER_TURN) begin
        x_next = -xa;
        z_next = zb - HALF_TURN;
      end else if (zb < -QUARTER_TURN) begin
        x_next = -xa;
        z_next = zb + HALF_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_func <= func;
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
    end
  end

endmodule

[hw/rtl/rpc_iter.sv]
// ----------------------------------------------------------------------------
// rpc_iter
// one registered micro-rotation of the cordic pipeline
// ----------------------------------------------------------------------------
module rpc_iter
  import rpc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0,
  localparam int XW = DATA_WIDTH + GUARD + 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic signed [XW-1:0]      in_x,
  input  logic signed [XW-1:0]      in_y,
  input  logic signed [ANGLE_W-1:0] in_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_func,
  output logic signed [XW-1:0]      out_x,
  output logic signed [XW-1:0]      out_y,
  output logic signed [ANGLE_W-1:0] out_z
);

  localparam logic signed [ANGLE_W-1:0] ATAN = $signed({2'b00, rpc_atan(IDX)});

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 up;

  assign in_ready = !out_valid || out_ready;
  assign dx = in_y >>> IDX;
  assign dy = in_x >>> IDX;
  // vectoring drives y to zero, rotation drives z to zero
  assign up = (in_func == FUNC_TO_POLAR) ? !in_y[XW-1] : in_z[ANGLE_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_func <= in_func;
      if (up) begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end else begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end
    end
  end

endmodule

[hw/rtl/rpc_scale.sv]
// ----------------------------------------------------------------------------
// rpc_scale
// gain correction, phase rounding and saturation; four register stages,
// the last one is the output register
// ----------------------------------------------------------------------------
module rpc_scale
  import rpc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int XW = DATA_WIDTH + GUARD + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [XW-1:0]         in_x,
  input  logic signed [XW-1:0]         in_y,
  input  logic signed [ANGLE_W-1:0]    in_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH:0]   result_a,
  output logic signed [DATA_WIDTH-1:0] result_b
);

  localparam int ASH = 32 - DATA_WIDTH;
  localparam int HW  = XW - SPLIT_W;
  localparam int LPW = SPLIT_W + 32;
  localparam int HPW = HW + 32;
  localparam int PW  = XW + 32;
  localparam int RW  = PW - 48;
  localparam int VW  = RW + 1;

  localparam logic signed [ANGLE_W-1:0] Z_RND = (ANGLE_W'(1) << ASH) >> 1;
  localparam logic [PW-1:0]             P_RND = PW'(1) << 47;
  localparam logic signed [VW-1:0]      SMAX_V = VW'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
  localparam logic signed [VW-1:0]      SMIN_V = -SMAX_V - VW'(1);
  localparam logic signed [VW-1:0]      MAG_MAX = VW'((64'sd1 <<< DATA_WIDTH) - 64'sd1);

  function automatic logic [DATA_WIDTH-1:0] sat_s(input logic signed [VW-1:0] v);
    logic [DATA_WIDTH-1:0] r;
    if (v > SMAX_V) begin
      r = SMAX_V[DATA_WIDTH-1:0];
    end else if (v < SMIN_V) begin
      r = SMIN_V[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // stage 1: magnitudes and phase rounding
  logic                  v1;
  logic                  rdy1;
  logic                  func1;
  logic                  negx1;
  logic                  negy1;
  logic [XW-1:0]         mx1;
  logic [XW-1:0]         my1;
  logic [DATA_WIDTH-1:0] ph1;
  logic [ANGLE_W-1:0]    zr;

  // stage 2: partial products
  logic                  v2;
  logic                  rdy2;
  logic                  func2;
  logic                  negx2;
  logic                  negy2;
  logic [LPW-1:0]        pxl2;
  logic [HPW-1:0]        pxh2;
  logic [LPW-1:0]        pyl2;
  logic [HPW-1:0]        pyh2;
  logic [DATA_WIDTH-1:0] ph2;

  // stage 3: sum, round, sign
  logic                  v3;
  logic                  rdy3;
  logic                  func3;
  logic signed [VW-1:0]  vx3;
  logic signed [VW-1:0]  vy3;
  logic [DATA_WIDTH-1:0] ph3;
  logic [PW-1:0]         sx;
  logic [PW-1:0]         sy;
  logic [RW-1:0]         rx;
  logic [RW-1:0]         ry;

  // stage 4: saturation
  logic                  rdy4;
  logic [DATA_WIDTH-1:0] mag;
  logic [DATA_WIDTH-1:0] ca;
  logic [DATA_WIDTH-1:0] cb;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign zr = in_z + Z_RND;

  always_comb begin
    sx = (PW'(pxh2) << SPLIT_W) + PW'(pxl2) + P_RND;
    sy = (PW'(pyh2) << SPLIT_W) + PW'(pyl2) + P_RND;
    rx = sx[PW-1:48];
    ry = sy[PW-1:48];
  end

  always_comb begin
    if (vx3 < 0) begin
      mag = '0;
    end else if (vx3 > MAG_MAX) begin
      mag = '1;
    end else begin
      mag = vx3[DATA_WIDTH-1:0];
    end
    ca = sat_s(vx3);
    cb = sat_s(vy3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      func1 <= in_func;
      negx1 <= in_x[XW-1];
      negy1 <= in_y[XW-1];
      mx1   <= in_x[XW-1] ? XW'(-in_x) : XW'(in_x);
      my1   <= in_y[XW-1] ? XW'(-in_y) : XW'(in_y);
      ph1   <= zr[ASH+DATA_WIDTH-1:ASH];
    end
    if (rdy2) begin
      func2 <= func1;
      negx2 <= negx1;
      negy2 <= negy1;
      pxl2  <= mx1[SPLIT_W-1:0] * INV_GAIN;
      pxh2  <= mx1[XW-1:SPLIT_W] * INV_GAIN;
      pyl2  <= my1[SPLIT_W-1:0] * INV_GAIN;
      pyh2  <= my1[XW-1:SPLIT_W] * INV_GAIN;
      ph2   <= ph1;
    end
    if (rdy3) begin
      func3 <= func2;
      vx3   <= negx2 ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
      vy3   <= negy2 ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
      ph3   <= ph2;
    end
    if (rdy4) begin
      if (func3 == FUNC_TO_POLAR) begin
        result_a <= $signed({1'b0, mag});
        result_b <= $signed(ph3);
      end else begin
        result_a <= $signed({ca[DATA_WIDTH-1], ca});
        result_b <= $signed(cb);
      end
    end
  end

endmodule

[hw/rtl/rect_polar_converter_top.sv]
// ----------------------------------------------------------------------------
// rect_polar_converter_top
// pipelined cordic conversion between rectangular and polar form
// ----------------------------------------------------------------------------
// requests enter on the s_axis channel: tuser selects the conversion
// (0 rectangular to polar, 1 polar to rectangular), tdata carries the two
// signed operands. each request yields one result on the m_axis channel:
// magnitude and phase, or real and imaginary part saturated to DATA_WIDTH bits.
// phase is in units of pi/2^(DATA_WIDTH-1).
// the pipeline has one input stage, one stage per cordic
// micro-rotation, and four stages for gain correction and saturation.
// a new request is taken every cycle; each stage advances when it is empty
// or the stage after it advances, so bubbles close up and s_axis_tready stays
// high while a result waits as long as some stage is free. when m_axis_tready
// is held low the pipeline fills, then s_axis_tready drops; nothing is lost.
// reset clears every stage valid bit; no state is kept between requests.
// ----------------------------------------------------------------------------
module rect_polar_converter_top
  import rpc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ITERATIONS = ITERATIONS_DEF,
  localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((2 * DATA_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // operand_a, operand_b
  input  logic                 s_axis_tuser,  // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // result_a, result_b
);

  localparam int XW    = DATA_WIDTH + GUARD + 3;
  localparam int NITER = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;

  logic                      vld  [NITER+1];
  logic                      rdy  [NITER+1];
  logic                      fn   [NITER+1];
  logic signed [XW-1:0]      xs   [NITER+1];
  logic signed [XW-1:0]      ys   [NITER+1];
  logic signed [ANGLE_W-1:0] zs   [NITER+1];

  logic signed [DATA_WIDTH:0]   result_a;
  logic signed [DATA_WIDTH-1:0] result_b;

  rpc_pre #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .func      (s_axis_tuser),
    .operand_a (s_axis_tdata[DATA_WIDTH-1:0]),
    .operand_b (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_func  (fn[0]),
    .out_x     (xs[0]),
    .out_y     (ys[0]),
    .out_z     (zs[0])
  );

  for (genvar i = 0; i < NITER; i++) begin : g_iter
    rpc_iter #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_iter (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_func   (fn[i]),
      .in_x      (xs[i]),
      .in_y      (ys[i]),
      .in_z      (zs[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_func  (fn[i+1]),
      .out_x     (xs[i+1]),
      .out_y     (ys[i+1]),
      .out_z     (zs[i+1])
    );
  end

  rpc_scale #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[NITER]),
    .in_ready  (rdy[NITER]),
    .in_func   (fn[NITER]),
    .in_x      (xs[NITER]),
    .in_y      (ys[NITER]),
    .in_z      (zs[NITER]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result_a  (result_a),
    .result_b  (result_b)
  );

  assign m_axis_tdata = {{(M_TDATA_W-2*DATA_WIDTH-1){1'b0}}, result_b, result_a};

endmodule

[tb/rect_polar_converter_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_polar_converter_top_test
// self-checking bench for the rectangular/polar cordic converter
// ----------------------------------------------------------------------------
// a queue of requests feeds a stream driver with random gaps between requests.
// each accepted request is run through a bit-exact cordic predictor in the
// bench, and the expected result is queued. a monitor with random stalls
// compares every result field by field against the oldest expected one. the
// requests are a directed set of corner cases followed by random operands.
// ----------------------------------------------------------------------------
module rect_polar_converter_top_test;
  import rpc_pkg::*;

  localparam int DW           = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = CORDIC_STEPS + 5;
  localparam int NUM_RANDOM   = 1300;

  localparam longint PI_ANG      = 64'sd2147483648;
  localparam longint HALF_PI_ANG = 64'sd1073741824;
  localparam longint unsigned GAIN_COMP = 64'd2608131496;

  typedef struct {
    logic                   fn;
    logic signed [DW-1:0]   a;
    logic signed [DW-1:0]   b;
    int unsigned            gap;
  } conv_request_t;

  typedef struct packed {
    logic signed [DW:0]     mag_or_re;
    logic signed [DW-1:0]   phase_or_im;
  } conv_result_t;

  // arctangent of 2^-i in units of pi/2^31, truncated
  longint atan_step [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
    64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051,
    64'h00000028, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000002, 64'h00000001, 64'h00000000, 64'h00000000
  };

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  conv_request_t request_queue [$];
  conv_request_t req_on_bus;
  conv_result_t  awaited_results [$];

  int unsigned idle_cycles  = 0;
  int unsigned rx_hold      = 0;
  bit          rx_calm      = 1'b0;
  int          fail_count   = 0;
  int          polar_reqs   = 0;
  int          rect_reqs    = 0;
  int          results_seen = 0;

  rect_polar_converter_top #(
    .DATA_WIDTH(DW),
    .ITERATIONS(CORDIC_STEPS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // round(v * gain_comp / 2^48), half away from zero
  function automatic longint gain_correct(longint v);
    logic            neg;
    longint unsigned m;
    longint unsigned p;
    longint unsigned r;
    neg = v < 0;
    m   = neg ? longint'(-v) : v;
    p   = (m >> 24) * GAIN_COMP + (((m & 64'hFFFFFF) * GAIN_COMP) >> 24);
    r   = (p + (64'd1 << 23)) >> 24;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic conv_result_t cordic_convert(logic fn, logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
    longint       x;
    longint       y;
    longint       z;
    longint       dx;
    longint       dy;
    longint       mag;
    longint       ph;
    longint       re;
    longint       im;
    int           i;
    conv_result_t r;
    x = longint'(a) <<< 16;
    if (fn == FUNC_TO_POLAR) begin
      y = longint'(b) <<< 16;
      z = 0;
      // negative real part: turn by pi first
      if (x < 0) begin
        z = (y >= 0) ? PI_ANG : -PI_ANG;
        x = -x;
        y = -y;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_step[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_step[i];
        end
      end
      mag = clamp(gain_correct(x), 0, 65535);
      ph  = (z + 32768) >>> 16;
      r.mag_or_re   = mag[DW:0];
      r.phase_or_im = ph[DW-1:0];
    end else begin
      y = 0;
      z = longint'(b) <<< 16;
      if (z > HALF_PI_ANG) begin
        x = -x;
        z = z - PI_ANG;
      end else if (z < -HALF_PI_ANG) begin
        x = -x;
        z = z + PI_ANG;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - atan_step[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + atan_step[i];
        end
      end
      re = clamp(gain_correct(x), -32768, 32767);
      im = clamp(gain_correct(y), -32768, 32767);
      r.mag_or_re   = re[DW:0];
      r.phase_or_im = im[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] pick_operand();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'sh7FFF;
      1:       v = 16'sh8000;
      2:       v = '0;
      3:       v = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      4:       v = 16'(int'($urandom_range(0, 64)) - 32);
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic add_request(logic fn, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                             bit calm);
    conv_request_t req;
    req.fn  = fn;
    req.a   = a;
    req.b   = b;
    req.gap = calm ? 0 : $urandom_range(0, 7);
    request_queue.push_back(req);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      idle_cycles   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(cordic_convert(req_on_bus.fn, req_on_bus.a, req_on_bus.b));
        if (req_on_bus.fn == FUNC_TO_POLAR) begin
          polar_reqs++;
        end else begin
          rect_reqs++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() != 0 && idle_cycles >= request_queue[0].gap) begin
          req_on_bus = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req_on_bus.b, req_on_bus.a};
          s_axis_tuser  <= req_on_bus.fn;
          idle_cycles   <= 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (request_queue.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
          end
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    conv_result_t exp_res;
    int unsigned  h;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no request pending: tdata=%h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (m_axis_tdata[16:0] !== exp_res.mag_or_re) begin
            $error("result_a: expected %0d, got %0d", exp_res.mag_or_re,
                   $signed(m_axis_tdata[16:0]));
            fail_count++;
          end
          if (m_axis_tdata[32:17] !== exp_res.phase_or_im) begin
            $error("result_b: expected %0d, got %0d", exp_res.phase_or_im,
                   $signed(m_axis_tdata[32:17]));
            fail_count++;
          end
          if (m_axis_tdata[39:33] !== 7'd0) begin
            $error("padding: expected 0, got %h", m_axis_tdata[39:33]);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          rx_calm = !rx_calm;
        end
        h = rx_calm ? 0 : $urandom_range(0, 7);
        m_axis_tready <= (h == 0);
        rx_hold       <= h;
      end else if (rx_hold > 0) begin
        m_axis_tready <= (rx_hold == 1);
        rx_hold       <= rx_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    bit calm;
    int n;
    // rectangular to polar corners
    add_request(FUNC_TO_POLAR, 16'sh7FFF, 16'sh0000, 1'b0);
    add_request(FUNC_TO_POLAR, 16'sh8000, 16'sh0000, 1'b0);
    add_request(FUNC_TO_POLAR, 16'sh0000, 16'sh7FFF, 1'b1);
    add_request(FUNC_TO_POLAR, 16'sh0000, 16'sh8000, 1'b0);
    add_request(FUNC_TO_POLAR, 16'sh0000, 16'sh0000, 1'b1);
    add_request(FUNC_TO_POLAR, 16'sh8000, 16'sh8000, 1'b0);
    add_request(FUNC_TO_POLAR, 16'sh7FFF, 16'sh7FFF, 1'b1);
    add_request(FUNC_TO_POLAR, -16'sd100, 16'sd0, 1'b0);
    add_request(FUNC_TO_POLAR, -16'sd5, 16'sd3, 1'b0);
    add_request(FUNC_TO_POLAR, -16'sd5, -16'sd3, 1'b1);
    add_request(FUNC_TO_POLAR, 16'sd1, -16'sd1, 1'b0);
    add_request(FUNC_TO_POLAR, 16'sh8000, 16'sh7FFF, 1'b1);
    // polar to rectangular corners
    add_request(FUNC_TO_RECT, 16'sh7FFF, 16'sh0000, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh7FFF, 16'sh7FFF, 1'b1);
    add_request(FUNC_TO_RECT, 16'sh7FFF, 16'sh8000, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh7FFF, 16'sd16384, 1'b1);
    add_request(FUNC_TO_RECT, 16'sh7FFF, 16'sd16385, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh7FFF, -16'sd16385, 1'b1);
    add_request(FUNC_TO_RECT, 16'sh7FFF, -16'sd16384, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh8000, 16'sh0000, 1'b1);
    add_request(FUNC_TO_RECT, 16'sh8000, 16'sd8192, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh7FFF, -16'sd8192, 1'b0);
    add_request(FUNC_TO_RECT, 16'sh0000, 16'sh7FFF, 1'b1);
    add_request(FUNC_TO_RECT, -16'sd1, 16'sh8000, 1'b0);
    calm = 1'b0;
    for (n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        calm = !calm;
      end
      add_request(1'($urandom_range(0, 1)), pick_operand(), pick_operand(), calm);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("converted %0d rectangular-to-polar and %0d polar-to-rectangular requests",
             polar_reqs, rect_reqs);
    $display("checked %0d results, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d requests unsent, %0d results outstanding",
             request_queue.size(), awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[rect_polar_converter_top.f]
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_pre.sv
hw/rtl/rpc_iter.sv
hw/rtl/rpc_scale.sv
hw/rtl/rect_polar_converter_top.sv
tb/rect_polar_converter_top_test.sv
